FILE: rtl/core/cdt_pkg.sv
package cdt_pkg;

    // Offset pointer width and working widths
    localparam int OFFSET_BITS   = 24;
    localparam int ADDR_BITS     = 32;
    localparam int SIZE_BITS     = 24;
    localparam int DIVIDEND_BITS = 32;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);

    // Commands
    localparam logic [3:0] CMD_ACQUIRE = 4'd0;
    localparam logic [3:0] CMD_PUT     = 4'd1;
    localparam logic [3:0] CMD_PREPARE = 4'd2;
    localparam logic [3:0] CMD_START   = 4'd3;
    localparam logic [3:0] CMD_STOP    = 4'd4;
    localparam logic [3:0] CMD_PAUSE   = 4'd5;
    localparam logic [3:0] CMD_RESUME  = 4'd6;
    localparam logic [3:0] CMD_COPY    = 4'd7;
    localparam logic [3:0] CMD_QUERY   = 4'd8;

    // Channel lifecycle
    localparam logic [2:0] LC_IDLE     = 3'd0;
    localparam logic [2:0] LC_ACQUIRED = 3'd1;
    localparam logic [2:0] LC_PREPARED = 3'd2;
    localparam logic [2:0] LC_ACTIVE   = 3'd3;
    localparam logic [2:0] LC_PAUSED   = 3'd4;

    // Result codes
    localparam logic [1:0] RC_OK    = 2'd0;
    localparam logic [1:0] RC_STATE = 2'd1;
    localparam logic [1:0] RC_NOPOS = 2'd2;

    // Hardware enable actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_ENABLE  = 2'd1;
    localparam logic [1:0] ACT_DISABLE = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_SIZE   = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;
    localparam logic [1:0] CFG_DIR    = 2'd3;

    typedef struct packed {
        logic [3:0]           command;
        logic [SIZE_BITS-1:0] byte_count;
        logic [ADDR_BITS-1:0] hw_position;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]           result_code;
        logic [2:0]           channel_state;
        logic [1:0]           hw_enable_action;
        logic [ADDR_BITS-1:0] read_address;
        logic [ADDR_BITS-1:0] write_address;
        logic [SIZE_BITS-1:0] avail_bytes;
        logic [SIZE_BITS-1:0] free_bytes;
    } t_res_item;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [SIZE_BITS-1:0]     divisor;
    } t_rem_req;

    typedef struct packed {
        logic                 done;
        logic [SIZE_BITS-1:0] remainder;
    } t_rem_rsp;

endpackage

FILE: rtl/core/cdt_rem.sv
// Restoring remainder unit, one dividend bit per cycle. Divisor zero gives zero.
module cdt_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdt_pkg::t_rem_req i_req,
    output cdt_pkg::t_rem_rsp o_rsp
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [cdt_pkg::STEP_BITS-1:0]     r_cnt, n_cnt;
    logic [cdt_pkg::DIVIDEND_BITS-1:0] r_dvd, n_dvd;
    logic [cdt_pkg::SIZE_BITS-1:0]     r_div, n_div;
    logic [cdt_pkg::SIZE_BITS-1:0]     r_rem, n_rem;
    logic [cdt_pkg::SIZE_BITS:0]       shifted;

    assign shifted = {r_rem, r_dvd[cdt_pkg::DIVIDEND_BITS-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_div  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[cdt_pkg::DIVIDEND_BITS-2:0], 1'b0};
            if (shifted >= {1'b0, r_div}) begin
                n_rem = cdt_pkg::SIZE_BITS'(shifted - {1'b0, r_div});
            end else begin
                n_rem = shifted[cdt_pkg::SIZE_BITS-1:0];
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == cdt_pkg::STEP_BITS'(cdt_pkg::DIVIDEND_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = (r_div == '0) ? '0 : r_rem;

endmodule

FILE: rtl/core/cyclic_dma_channel_tracker_core.sv
// Channel    | direction | handshake              | payload
// -----------+-----------+------------------------+-------------------------
// command in | in        | i_in_valid / o_in_stall | i_in_data  (t_cmd_item)
// result out | out       | o_out_valid / i_out_stall | o_out_data (t_res_item)
// config     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Lifecycle commands pass through S_OUT to the output register. Copy takes one
// 32-step pass of the shared remainder unit; a query with a known position
// takes two passes (mod buffer size, then mod period unless the period is zero).
// One transaction is in flight at a time.
// Reset is synchronous: lifecycle idle, offsets zero, registers to defaults.
// A result waits in the output register under stall while the next command
// is taken; the sequencer only holds if that register is still full.
module cyclic_dma_channel_tracker_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cdt_pkg::t_cmd_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cdt_pkg::t_res_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_QDIFF,
        S_QMOD,
        S_QPER,
        S_QSAT,
        S_OUT
    } t_state;

    // Configuration registers
    logic [cdt_pkg::ADDR_BITS-1:0]   r_base, n_base;
    logic [cdt_pkg::SIZE_BITS-1:0]   r_size, n_size;
    logic [cdt_pkg::SIZE_BITS-1:0]   r_period, n_period;
    logic                            r_play, n_play;

    // Channel state
    logic [2:0]                      r_lc, n_lc;
    logic [cdt_pkg::OFFSET_BITS-1:0] r_rd_off, n_rd_off;
    logic [cdt_pkg::OFFSET_BITS-1:0] r_wr_off, n_wr_off;

    // Sequencer and datapath
    t_state                          r_state, n_state;
    cdt_pkg::t_res_item              r_res, n_res;
    cdt_pkg::t_res_item              r_out, n_out;
    logic                            r_out_valid, n_out_valid;
    logic [cdt_pkg::SIZE_BITS:0]     r_avail, n_avail;
    cdt_pkg::t_rem_req               r_req, n_req;
    cdt_pkg::t_rem_rsp               rem_rsp;

    cdt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (rem_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [cdt_pkg::ADDR_BITS-1:0]   rel;
        logic [cdt_pkg::OFFSET_BITS:0]   sum;
        logic [cdt_pkg::ADDR_BITS-1:0]   diff;
        logic [cdt_pkg::SIZE_BITS-1:0]   sat;

        rel  = i_in_data.hw_position - r_base;
        sum  = '0;
        diff = '0;
        sat  = '0;

        n_base      = r_base;
        n_size      = r_size;
        n_period    = r_period;
        n_play      = r_play;
        n_lc        = r_lc;
        n_rd_off    = r_rd_off;
        n_wr_off    = r_wr_off;
        n_state     = r_state;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_avail     = r_avail;
        n_req       = r_req;
        n_req.start = 1'b0;

        // config write transaction
        if (i_cfg_valid) begin
            case (i_cfg_index)
                cdt_pkg::CFG_BASE:   n_base   = i_cfg_data;
                cdt_pkg::CFG_SIZE:   n_size   = i_cfg_data[cdt_pkg::SIZE_BITS-1:0];
                cdt_pkg::CFG_PERIOD: n_period = i_cfg_data[cdt_pkg::SIZE_BITS-1:0];
                cdt_pkg::CFG_DIR:    n_play   = i_cfg_data[0];
                default:             n_base   = r_base;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res             = '0;
                    n_res.result_code = cdt_pkg::RC_OK;
                    n_state           = S_OUT;
                    case (i_in_data.command)
                        cdt_pkg::CMD_ACQUIRE: begin
                            if (r_lc == cdt_pkg::LC_IDLE) n_lc = cdt_pkg::LC_ACQUIRED;
                            else n_res.result_code = cdt_pkg::RC_STATE;
                        end
                        cdt_pkg::CMD_PUT: begin
                            if (r_lc == cdt_pkg::LC_ACQUIRED || r_lc == cdt_pkg::LC_PREPARED)
                                n_lc = cdt_pkg::LC_IDLE;
                            else n_res.result_code = cdt_pkg::RC_STATE;
                        end
                        cdt_pkg::CMD_PREPARE: begin
                            if (r_lc == cdt_pkg::LC_ACQUIRED ||
                                r_lc == cdt_pkg::LC_PREPARED) begin
                                n_lc     = cdt_pkg::LC_PREPARED;
                                n_rd_off = '0;
                                n_wr_off = '0;
                            end else begin
                                n_res.result_code = cdt_pkg::RC_STATE;
                            end
                        end
                        cdt_pkg::CMD_START: begin
                            if (r_lc == cdt_pkg::LC_PREPARED) begin
                                n_lc                   = cdt_pkg::LC_ACTIVE;
                                n_res.hw_enable_action = cdt_pkg::ACT_ENABLE;
                            end else begin
                                n_res.result_code = cdt_pkg::RC_STATE;
                            end
                        end
                        cdt_pkg::CMD_STOP: begin
                            if (r_lc == cdt_pkg::LC_ACTIVE || r_lc == cdt_pkg::LC_PAUSED) begin
                                n_lc                   = cdt_pkg::LC_ACQUIRED;
                                n_res.hw_enable_action = cdt_pkg::ACT_DISABLE;
                            end else if (r_lc == cdt_pkg::LC_IDLE) begin
                                n_res.result_code = cdt_pkg::RC_STATE;
                            end
                        end
                        cdt_pkg::CMD_PAUSE: begin
                            if (r_lc == cdt_pkg::LC_ACTIVE) begin
                                n_lc                   = cdt_pkg::LC_PAUSED;
                                n_res.hw_enable_action = cdt_pkg::ACT_DISABLE;
                            end else begin
                                n_res.result_code = cdt_pkg::RC_STATE;
                            end
                        end
                        cdt_pkg::CMD_RESUME: begin
                            if (r_lc == cdt_pkg::LC_PAUSED) begin
                                n_lc                   = cdt_pkg::LC_ACTIVE;
                                n_res.hw_enable_action = cdt_pkg::ACT_ENABLE;
                            end else begin
                                n_res.result_code = cdt_pkg::RC_STATE;
                            end
                        end
                        cdt_pkg::CMD_COPY: begin
                            // software pointer: write for playback, read for capture
                            if (r_play) sum = {1'b0, r_wr_off} + {1'b0, i_in_data.byte_count};
                            else        sum = {1'b0, r_rd_off} + {1'b0, i_in_data.byte_count};
                            n_req.start    = 1'b1;
                            n_req.dividend = cdt_pkg::DIVIDEND_BITS'(sum);
                            n_req.divisor  = r_size;
                            n_state        = S_COPY;
                        end
                        cdt_pkg::CMD_QUERY: begin
                            if (i_in_data.hw_position == '0) begin
                                n_res.result_code = cdt_pkg::RC_NOPOS;
                            end else begin
                                // hardware pointer, not reduced by buffer size
                                if (r_play) n_rd_off = rel[cdt_pkg::OFFSET_BITS-1:0];
                                else        n_wr_off = rel[cdt_pkg::OFFSET_BITS-1:0];
                                n_state = S_QDIFF;
                            end
                        end
                        default: n_res.result_code = cdt_pkg::RC_STATE;
                    endcase
                    n_res.channel_state = n_lc;
                end
            end
            S_COPY: begin
                if (rem_rsp.done) begin
                    if (r_play) n_wr_off = rem_rsp.remainder;
                    else        n_rd_off = rem_rsp.remainder;
                    n_state = S_OUT;
                end
            end
            S_QDIFF: begin
                // may go negative, wraps at 32 bits like the bus math
                diff = cdt_pkg::ADDR_BITS'(r_wr_off) + cdt_pkg::ADDR_BITS'(r_size)
                     - cdt_pkg::ADDR_BITS'(r_rd_off);
                n_req.start    = 1'b1;
                n_req.dividend = diff;
                n_req.divisor  = r_size;
                n_state        = S_QMOD;
            end
            S_QMOD: begin
                if (rem_rsp.done) begin
                    n_avail = {1'b0, rem_rsp.remainder};
                    if (r_period != '0) begin
                        n_req.start    = 1'b1;
                        n_req.dividend = cdt_pkg::DIVIDEND_BITS'(rem_rsp.remainder);
                        n_req.divisor  = r_period;
                        n_state        = S_QPER;
                    end else begin
                        n_state = S_QSAT;
                    end
                end
            end
            S_QPER: begin
                if (rem_rsp.done) begin
                    // round up to whole periods for playback, down for capture
                    if (rem_rsp.remainder != '0) begin
                        if (r_play) n_avail = r_avail + {1'b0, r_period}
                                            - {1'b0, rem_rsp.remainder};
                        else        n_avail = r_avail - {1'b0, rem_rsp.remainder};
                    end
                    n_state = S_QSAT;
                end
            end
            S_QSAT: begin
                if (r_avail > {1'b0, r_size}) sat = r_size;
                else                          sat = r_avail[cdt_pkg::SIZE_BITS-1:0];
                n_res.avail_bytes   = sat;
                n_res.free_bytes    = r_size - sat;
                n_res.read_address  = cdt_pkg::ADDR_BITS'(r_rd_off) + r_base;
                n_res.write_address = cdt_pkg::ADDR_BITS'(r_wr_off) + r_base;
                n_state             = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= cdt_pkg::SIZE_BITS'(1);
            r_period    <= cdt_pkg::SIZE_BITS'(1);
            r_play      <= 1'b0;
            r_lc        <= cdt_pkg::LC_IDLE;
            r_rd_off    <= '0;
            r_wr_off    <= '0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_size      <= n_size;
            r_period    <= n_period;
            r_play      <= n_play;
            r_lc        <= n_lc;
            r_rd_off    <= n_rd_off;
            r_wr_off    <= n_wr_off;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_req.start <= n_req.start;
        end
        r_req.dividend <= n_req.dividend;
        r_req.divisor  <= n_req.divisor;
        r_res          <= n_res;
        r_out          <= n_out;
        r_avail        <= n_avail;
    end

endmodule
